// ===== design/gaussian_polar_noise_generator_macros.svh =====
// Assertion helpers, used by gpng_out.
`ifndef GAUSSIAN_POLAR_NOISE_GENERATOR_MACROS_SVH
`define GAUSSIAN_POLAR_NOISE_GENERATOR_MACROS_SVH

// same-cycle implication, checked outside reset
`define GPNG_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("gpng: same-cycle check failed");

// next-cycle implication, checked outside reset
`define GPNG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("gpng: next-cycle check failed");

`endif

// ===== design/gpng_pkg.sv =====
`default_nettype none
package gpng_pkg;

    // widest supported sum of squares (UNIFORM_BITS = 32)
    localparam int SN_MAX_W   = 62;
    localparam int EXP_W      = 6;
    localparam int M_W        = 31;   // mantissa / divider operand width
    localparam int FRAC_W     = 24;
    localparam int L_W        = 30;
    localparam int KL_W       = 31;
    localparam int LOG_STEPS  = 24;
    localparam int Q_W        = 33;   // quotient bits
    localparam int DIV_STEPS  = Q_W;
    localparam int KL_HOLD    = DIV_STEPS - LOG_STEPS - 1;
    localparam int Q_LO_W     = 16;
    localparam int Z2_W       = 31;
    localparam int SQ_IN_W    = 56;
    localparam int ROOT_W     = SQ_IN_W / 2;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int REM_W      = ROOT_W + 2;
    localparam int LANE_LAT   = SQRT_STEPS + 4;
    localparam int CFG_W      = 16;
    localparam int SAMPLE_W   = 24;
    localparam int PDATA_W    = 32;
    localparam int PADDR_W    = 3;

    localparam logic [EXP_W-1:0] NORM_TOP    = EXP_W'(M_W - 1);
    localparam logic [M_W-1:0]   TWO_LN2_Q30 = 31'd1488522236;
    localparam int               KL_SHIFT    = 30;

    localparam logic signed [SAMPLE_W:0] SAMPLE_MAX = 25'sd8388607;
    localparam logic signed [SAMPLE_W:0] SAMPLE_MIN = -25'sd8388608;

    localparam logic [CFG_W-1:0] SCALE_RESET = 16'd256;

    typedef enum logic [0:0] {
        REG_MEAN  = 1'b0,
        REG_SCALE = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic neg_a;
        logic neg_b;
    } t_pair_tag;

endpackage
`default_nettype wire

// ===== design/gpng_prep.sv =====
`default_nettype none
module gpng_prep #(
    parameter int UNIFORM_BITS = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  wire logic                       i_valid,
    input  wire logic [UNIFORM_BITS-1:0]    i_first_uniform,
    input  wire logic [UNIFORM_BITS-1:0]    i_second_uniform,
    output logic                            o_valid,
    output gpng_pkg::t_pair_tag             o_tag,
    output logic [gpng_pkg::M_W-1:0]        o_m,
    output logic [gpng_pkg::EXP_W-1:0]      o_e,
    output logic [gpng_pkg::M_W-1:0]        o_num_a,
    output logic [gpng_pkg::M_W-1:0]        o_num_b,
    output logic [gpng_pkg::M_W-1:0]        o_den
);
    import gpng_pkg::*;

    localparam int W    = UNIFORM_BITS;
    localparam int SN_W = 2 * W - 2;
    localparam logic [W-1:0] HALF = {1'b1, {(W-1){1'b0}}};

    logic [4:0] r_vld;
    t_pair_tag  r_tag [5];

    logic [W-1:0]      n1_ma, n1_mb, r1_ma, r1_mb;
    logic [2*W-1:0]    n2_ca, n2_cb, r2_ca, r2_cb;
    logic [2*W-1:0]    n3_sum;
    logic              n3_ok;
    logic [SN_W-1:0]   r3_sn, r3_ca, r3_cb;
    logic [EXP_W-1:0]  n4_e, r4_e;
    logic [SN_W-1:0]   r4_sn, r4_ca, r4_cb;
    logic [SN_MAX_W-1:0] sn62, ca62, cb62;
    logic [EXP_W-1:0]  sh_r, sh_l;
    logic              big;
    logic [M_W-1:0]    n5_m, n5_a, n5_b, n5_d;
    logic [M_W-1:0]    r5_m, r5_a, r5_b, r5_d;
    logic [EXP_W-1:0]  r5_e;

    // magnitude of raw - HALF
    assign n1_ma = i_first_uniform[W-1]  ? {1'b0, i_first_uniform[W-2:0]}
                                         : HALF - i_first_uniform;
    assign n1_mb = i_second_uniform[W-1] ? {1'b0, i_second_uniform[W-2:0]}
                                         : HALF - i_second_uniform;

    assign n2_ca = r1_ma * r1_ma;
    assign n2_cb = r1_mb * r1_mb;

    // reject S == 0 and S >= 1
    assign n3_sum = r2_ca + r2_cb;
    assign n3_ok  = (n3_sum != '0) && (n3_sum[2*W-1:SN_W] == '0);

    always_comb begin
        n4_e = '0;
        for (int i = 0; i < SN_W; i++) begin
            if (r3_sn[i]) begin
                n4_e = EXP_W'(i);
            end
        end
    end

    assign sn62 = SN_MAX_W'(r4_sn);
    assign ca62 = SN_MAX_W'(r4_ca);
    assign cb62 = SN_MAX_W'(r4_cb);
    assign big  = r4_e > NORM_TOP;
    assign sh_r = r4_e - NORM_TOP;
    assign sh_l = NORM_TOP - r4_e;
    assign n5_m = big ? M_W'(sn62 >> sh_r) : M_W'(sn62 << sh_l);
    assign n5_a = big ? M_W'(ca62 >> sh_r) : M_W'(ca62);
    assign n5_b = big ? M_W'(cb62 >> sh_r) : M_W'(cb62);
    assign n5_d = big ? n5_m : M_W'(sn62);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3], r_vld[2], r_vld[1] & n3_ok, r_vld[0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag[0] <= '{neg_a: !i_first_uniform[W-1], neg_b: !i_second_uniform[W-1]};
            for (int s = 1; s < 5; s++) begin
                r_tag[s] <= r_tag[s-1];
            end
            r1_ma <= n1_ma;
            r1_mb <= n1_mb;
            r2_ca <= n2_ca;
            r2_cb <= n2_cb;
            r3_sn <= n3_sum[SN_W-1:0];
            r3_ca <= r2_ca[SN_W-1:0];
            r3_cb <= r2_cb[SN_W-1:0];
            r4_e  <= n4_e;
            r4_sn <= r3_sn;
            r4_ca <= r3_ca;
            r4_cb <= r3_cb;
            r5_m  <= n5_m;
            r5_a  <= n5_a;
            r5_b  <= n5_b;
            r5_d  <= n5_d;
            r5_e  <= r4_e;
        end
    end

    assign o_valid = r_vld[4];
    assign o_tag   = r_tag[4];
    assign o_m     = r5_m;
    assign o_e     = r5_e;
    assign o_num_a = r5_a;
    assign o_num_b = r5_b;
    assign o_den   = r5_d;

endmodule
`default_nettype wire

// ===== design/gpng_log.sv =====
`default_nettype none
module gpng_log #(
    parameter int UNIFORM_BITS = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  wire logic                       i_valid,
    input  wire gpng_pkg::t_pair_tag        i_tag,
    input  wire logic [gpng_pkg::M_W-1:0]   i_m,
    input  wire logic [gpng_pkg::EXP_W-1:0] i_e,
    output logic                            o_valid,
    output gpng_pkg::t_pair_tag             o_tag,
    output logic [gpng_pkg::KL_W-1:0]       o_kl
);
    import gpng_pkg::*;

    localparam int SN_W = 2 * UNIFORM_BITS - 2;

    logic [M_W-1:0]    r_m    [LOG_STEPS];
    logic [FRAC_W-1:0] r_frac [LOG_STEPS];
    logic [EXP_W-1:0]  r_e    [LOG_STEPS];
    logic [L_W-1:0]    n_l, r_l;
    logic [M_W+L_W-1:0] kl_prod;
    logic [KL_W-1:0]   r_kl   [KL_HOLD];
    logic              r_vld  [DIV_STEPS];
    t_pair_tag         r_tag  [DIV_STEPS];

    // fraction bits of log2 by repeated squaring, one bit per stage
    for (genvar j = 0; j < LOG_STEPS; j++) begin : g_sq
        logic [M_W-1:0]    m_in;
        logic [FRAC_W-1:0] f_in;
        logic [EXP_W-1:0]  e_in;
        logic [2*M_W-1:0]  prod;
        logic [M_W:0]      top;
        if (j == 0) begin : g_first
            assign m_in = i_m;
            assign f_in = '0;
            assign e_in = i_e;
        end else begin : g_next
            assign m_in = r_m[j-1];
            assign f_in = r_frac[j-1];
            assign e_in = r_e[j-1];
        end
        assign prod = m_in * m_in;
        assign top  = prod[2*M_W-1:M_W-1];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m[j]    <= top[M_W] ? top[M_W:1] : top[M_W-1:0];
                r_frac[j] <= {f_in[FRAC_W-2:0], top[M_W]};
                r_e[j]    <= e_in;
            end
        end
    end

    // -log2(S) in Q24
    assign n_l = {EXP_W'(SN_W) - r_e[LOG_STEPS-1], FRAC_W'(0)}
               - L_W'(r_frac[LOG_STEPS-1]);
    assign kl_prod = TWO_LN2_Q30 * r_l;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_l     <= n_l;
            r_kl[0] <= kl_prod[KL_SHIFT+KL_W-1:KL_SHIFT];
            for (int k = 1; k < KL_HOLD; k++) begin
                r_kl[k] <= r_kl[k-1];
            end
            r_tag[0] <= i_tag;
            for (int s = 1; s < DIV_STEPS; s++) begin
                r_tag[s] <= r_tag[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DIV_STEPS; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int s = 1; s < DIV_STEPS; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    assign o_valid = r_vld[DIV_STEPS-1];
    assign o_tag   = r_tag[DIV_STEPS-1];
    assign o_kl    = r_kl[KL_HOLD-1];

endmodule
`default_nettype wire

// ===== design/gpng_div.sv =====
`default_nettype none
module gpng_div (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic [gpng_pkg::M_W-1:0] i_num,
    input  wire logic [gpng_pkg::M_W-1:0] i_den,
    output logic [gpng_pkg::Q_W-1:0]      o_q
);
    import gpng_pkg::*;

    // (num << 32) / den with num <= den: restoring, one quotient bit per stage
    logic [M_W-1:0] r_rem [DIV_STEPS];
    logic [M_W-1:0] r_d   [DIV_STEPS];
    logic [Q_W-1:0] r_q   [DIV_STEPS];

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_stg
        logic [M_W:0]   rem_in;
        logic [M_W-1:0] d_in;
        logic [Q_W-1:0] q_in;
        logic           ge;
        if (j == 0) begin : g_first
            assign rem_in = {1'b0, i_num};
            assign d_in   = i_den;
            assign q_in   = '0;
        end else begin : g_next
            assign rem_in = {r_rem[j-1], 1'b0};
            assign d_in   = r_d[j-1];
            assign q_in   = r_q[j-1];
        end
        assign ge = rem_in >= {1'b0, d_in};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= ge ? M_W'(rem_in - {1'b0, d_in}) : M_W'(rem_in);
                r_d[j]   <= d_in;
                r_q[j]   <= {q_in[Q_W-2:0], ge};
            end
        end
    end

    assign o_q = r_q[DIV_STEPS-1];

endmodule
`default_nettype wire

// ===== design/gpng_lane.sv =====
`default_nettype none
module gpng_lane (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_en,
    input  wire logic                            i_valid,
    input  wire logic                            i_neg,
    input  wire logic [gpng_pkg::Q_W-1:0]        i_q,
    input  wire logic [gpng_pkg::KL_W-1:0]       i_kl,
    input  wire logic [gpng_pkg::CFG_W-1:0]      i_scale,
    input  wire logic signed [gpng_pkg::CFG_W-1:0] i_mean,
    output logic                                 o_valid,
    output logic signed [gpng_pkg::SAMPLE_W-1:0] o_sample
);
    import gpng_pkg::*;

    localparam int PLO_W  = Q_LO_W + KL_W;
    localparam int PHI_W  = Q_W - Q_LO_W + KL_W;
    localparam int FULL_W = PHI_W + Q_LO_W;
    localparam int PROD_W = ROOT_W + CFG_W;
    localparam int Q8_W   = PROD_W + 1 - FRAC_W;

    logic              r_vld [LANE_LAT];
    logic              r_neg [LANE_LAT];
    logic [PLO_W-1:0]  r_p_lo;
    logic [PHI_W-1:0]  r_p_hi;
    logic [FULL_W-1:0] full;
    logic [Z2_W-1:0]   r_z2;
    logic [REM_W-1:0]  r_rem  [SQRT_STEPS];
    logic [ROOT_W-1:0] r_root [SQRT_STEPS];
    logic [SQ_IN_W-1:0] r_x   [SQRT_STEPS];
    logic [PROD_W-1:0] r_prod;
    logic [PROD_W:0]   rounded;
    logic [Q8_W-1:0]   q8;
    logic signed [Q8_W:0]     sv;
    logic signed [SAMPLE_W:0] sum;
    logic signed [SAMPLE_W-1:0] n_sample, r_sample;

    // z2 = (r * kl) >> 32, product split in two halves of r
    assign full = {r_p_hi, Q_LO_W'(0)} + FULL_W'(r_p_lo);

    // floor(sqrt(z2 << 24)), one root bit per stage
    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        logic [REM_W-1:0]   rem_in;
        logic [ROOT_W-1:0]  root_in;
        logic [SQ_IN_W-1:0] x_in;
        logic [REM_W+1:0]   t;
        logic [REM_W+1:0]   trial;
        logic               ge;
        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign x_in    = SQ_IN_W'({r_z2, FRAC_W'(0)});
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign x_in    = r_x[k-1];
        end
        assign t     = {rem_in, x_in[SQ_IN_W-1:SQ_IN_W-2]};
        assign trial = {2'b00, root_in, 2'b01};
        assign ge    = t >= trial;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= ge ? REM_W'(t - trial) : REM_W'(t);
                r_root[k] <= {root_in[ROOT_W-2:0], ge};
                r_x[k]    <= {x_in[SQ_IN_W-3:0], 2'b00};
            end
        end
    end

    // scale, round half away from zero, add mean, saturate
    assign rounded = (PROD_W+1)'(r_prod) + (PROD_W+1)'(1 << (FRAC_W - 1));
    assign q8      = rounded[PROD_W:FRAC_W];
    assign sv      = r_neg[LANE_LAT-2] ? -$signed({1'b0, q8}) : $signed({1'b0, q8});
    assign sum     = (SAMPLE_W+1)'(sv) + (SAMPLE_W+1)'(i_mean);

    always_comb begin
        if (sum > SAMPLE_MAX) begin
            n_sample = SAMPLE_MAX[SAMPLE_W-1:0];
        end else if (sum < SAMPLE_MIN) begin
            n_sample = SAMPLE_MIN[SAMPLE_W-1:0];
        end else begin
            n_sample = sum[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_lo   <= i_q[Q_LO_W-1:0] * i_kl;
            r_p_hi   <= i_q[Q_W-1:Q_LO_W] * i_kl;
            r_z2     <= Z2_W'(full[FULL_W-1:2*Q_LO_W]);
            r_prod   <= r_root[SQRT_STEPS-1] * i_scale;
            r_sample <= n_sample;
            r_neg[0] <= i_neg;
            for (int s = 1; s < LANE_LAT; s++) begin
                r_neg[s] <= r_neg[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < LANE_LAT; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int s = 1; s < LANE_LAT; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    assign o_valid  = r_vld[LANE_LAT-1];
    assign o_sample = r_sample;

endmodule
`default_nettype wire

// ===== design/gpng_out.sv =====
`default_nettype none
`include "gaussian_polar_noise_generator_macros.svh"
module gpng_out (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_pair_valid,
    input  wire logic signed [gpng_pkg::SAMPLE_W-1:0] i_sample_a,
    input  wire logic signed [gpng_pkg::SAMPLE_W-1:0] i_sample_b,
    input  wire logic                                i_ready,
    output logic                                     o_advance,
    output logic                                     o_valid,
    output logic signed [gpng_pkg::SAMPLE_W-1:0]     o_sample,
    output logic                                     o_last
);
    import gpng_pkg::*;

    logic r_valid, n_valid;
    logic r_pend, n_pend;
    logic r_last, n_last;
    logic signed [SAMPLE_W-1:0] r_sample, n_sample;
    logic signed [SAMPLE_W-1:0] r_second, n_second;
    logic can_take, take;

    // a pair enters only when the second sample has a free slot
    assign can_take  = !r_valid || (i_ready && !r_pend);
    assign take      = i_pair_valid && can_take;
    assign o_advance = !i_pair_valid || can_take;

    always_comb begin
        n_valid  = r_valid;
        n_pend   = r_pend;
        n_last   = r_last;
        n_sample = r_sample;
        n_second = r_second;
        if (take) begin
            n_valid  = 1'b1;
            n_pend   = 1'b1;
            n_last   = 1'b0;
            n_sample = i_sample_a;
            n_second = i_sample_b;
        end else if (r_valid && i_ready) begin
            if (r_pend) begin
                n_pend   = 1'b0;
                n_last   = 1'b1;
                n_sample = r_second;
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last   <= n_last;
        r_sample <= n_sample;
        r_second <= n_second;
    end

    assign o_valid  = r_valid;
    assign o_sample = r_sample;
    assign o_last   = r_last;

    `GPNG_ASSERT_NEXT(a_pair_shows_first, i_clk, i_rst_n, take, r_valid && !r_last)
    `GPNG_ASSERT_NEXT(a_second_follows, i_clk, i_rst_n, r_valid && i_ready && r_pend, r_valid && r_last)
    `GPNG_ASSERT_NOW(a_pend_with_first, i_clk, i_rst_n, r_pend, r_valid && !r_last)

endmodule
`default_nettype wire

// ===== design/gaussian_polar_noise_generator.sv =====
`default_nettype none
// Channel   Direction  Handshake            Payload
// input     in         i_valid / o_ready    i_first_uniform, i_second_uniform
// output    out        o_valid / i_ready    o_sample (Q16.8), o_last
// config    in         psel/penable/pready  paddr, pwdata, pwrite -> prdata
//
// A pair may enter every cycle unless stalled; an accepted pair gives two samples,
// one per cycle while i_ready is high, so the single output register limits the pair rate.
// 71 register stages (5 prep, 33 log/divide, 32 lane, 1 out) lie between an accepted
// input request and its first valid sample.
// Rejected pairs travel as bubbles and give nothing.
// Reset is synchronous, active low; it clears the valid bits and sets mean 0, scale 1.0.
// An output stall with a pair waiting freezes the pipeline; nothing is lost or repeated.
module gaussian_polar_noise_generator #(
    parameter int UNIFORM_BITS = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic [UNIFORM_BITS-1:0]           i_first_uniform,
    input  wire logic [UNIFORM_BITS-1:0]           i_second_uniform,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic signed [gpng_pkg::SAMPLE_W-1:0]   o_sample,
    output logic                                   o_last,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [gpng_pkg::PADDR_W-1:0]      paddr,
    input  wire logic [gpng_pkg::PDATA_W-1:0]      pwdata,
    output logic [gpng_pkg::PDATA_W-1:0]           prdata,
    output logic                                   pready
);
    import gpng_pkg::*;

    logic                     en;
    logic signed [CFG_W-1:0]  r_mean;
    logic [CFG_W-1:0]         r_scale;
    t_reg_idx                 reg_idx;

    logic                     pre_valid;
    t_pair_tag                pre_tag;
    logic [M_W-1:0]           pre_m, pre_num_a, pre_num_b, pre_den;
    logic [EXP_W-1:0]         pre_e;
    logic                     log_valid;
    t_pair_tag                log_tag;
    logic [KL_W-1:0]          log_kl;
    logic [Q_W-1:0]           q_a, q_b;
    logic                     lane_vld_a, lane_vld_b;
    logic signed [SAMPLE_W-1:0] smp_a, smp_b;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean  <= '0;
            r_scale <= SCALE_RESET;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                REG_MEAN:  r_mean  <= pwdata[CFG_W-1:0];
                REG_SCALE: r_scale <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MEAN:  prdata = {{(PDATA_W-CFG_W){1'b0}}, r_mean};
            REG_SCALE: prdata = {{(PDATA_W-CFG_W){1'b0}}, r_scale};
            default:   prdata = '0;
        endcase
    end

    assign o_ready = en;

    gpng_prep #(.UNIFORM_BITS(UNIFORM_BITS)) u_prep (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (en),
        .i_valid          (i_valid),
        .i_first_uniform  (i_first_uniform),
        .i_second_uniform (i_second_uniform),
        .o_valid          (pre_valid),
        .o_tag            (pre_tag),
        .o_m              (pre_m),
        .o_e              (pre_e),
        .o_num_a          (pre_num_a),
        .o_num_b          (pre_num_b),
        .o_den            (pre_den)
    );

    gpng_log #(.UNIFORM_BITS(UNIFORM_BITS)) u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (pre_valid),
        .i_tag   (pre_tag),
        .i_m     (pre_m),
        .i_e     (pre_e),
        .o_valid (log_valid),
        .o_tag   (log_tag),
        .o_kl    (log_kl)
    );

    gpng_div u_div_a (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (pre_num_a),
        .i_den (pre_den),
        .o_q   (q_a)
    );

    gpng_div u_div_b (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (pre_num_b),
        .i_den (pre_den),
        .o_q   (q_b)
    );

    gpng_lane u_lane_a (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (log_valid),
        .i_neg    (log_tag.neg_a),
        .i_q      (q_a),
        .i_kl     (log_kl),
        .i_scale  (r_scale),
        .i_mean   (r_mean),
        .o_valid  (lane_vld_a),
        .o_sample (smp_a)
    );

    gpng_lane u_lane_b (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (log_valid),
        .i_neg    (log_tag.neg_b),
        .i_q      (q_b),
        .i_kl     (log_kl),
        .i_scale  (r_scale),
        .i_mean   (r_mean),
        .o_valid  (lane_vld_b),
        .o_sample (smp_b)
    );

    gpng_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pair_valid (lane_vld_a && lane_vld_b),
        .i_sample_a   (smp_a),
        .i_sample_b   (smp_b),
        .i_ready      (i_ready),
        .o_advance    (en),
        .o_valid      (o_valid),
        .o_sample     (o_sample),
        .o_last       (o_last)
    );

endmodule
`default_nettype wire
